>>> hdl/assert_macros.svh
// Assertion macros shared by the link protocol RTL.
// Every macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SEBL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("link protocol assertion failed");

// Next-cycle implication.
`define SEBL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("link protocol assertion failed");

`endif

>>> hdl/sebl_pkg.sv
// Shared types, codes and result helpers for the STX/ETX/BCC link protocol core.
// No dependencies; used by sebl_engine, sebl_obuf and the top level.
package sebl_pkg;

    localparam int BUF_SIZE = 16384;
    localparam int RCNT_W   = 15;
    localparam int IDX_W    = 14;

    // Command codes
    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_BYTE    = 3'd1;
    localparam logic [2:0] CMD_CONNECT = 3'd2;
    localparam logic [2:0] CMD_DISCONN = 3'd3;
    localparam logic [2:0] CMD_TIMEOUT = 3'd4;

    // Start modes
    localparam logic [1:0] MODE_DIAL   = 2'd0;
    localparam logic [1:0] MODE_ACCEPT = 2'd1;
    localparam logic [1:0] MODE_SEND   = 2'd2;
    localparam logic [1:0] MODE_RECV   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_LINE_IS_TCP = 2'd0;
    localparam logic [1:0] CFG_MAX_RETRIES = 2'd1;
    localparam logic [1:0] CFG_TCP_TIMEOUT = 2'd2;

    // Line control characters
    localparam logic [7:0] C_STX = 8'h02;
    localparam logic [7:0] C_ETX = 8'h03;
    localparam logic [7:0] C_EOT = 8'h04;
    localparam logic [7:0] C_ENQ = 8'h05;
    localparam logic [7:0] C_ACK = 8'h06;
    localparam logic [7:0] C_NAK = 8'h15;

    // Timer values in seconds
    localparam logic [7:0] T_CONNECT = 8'd60;
    localparam logic [7:0] T_ENQWAIT = 8'd7;
    localparam logic [7:0] T_NEGOT   = 8'd10;
    localparam logic [7:0] T_RECV    = 8'd30;

    typedef enum logic [3:0] {
        PH_IDLE, PH_DIAL, PH_ENQ, PH_ACCEPT, PH_CONN, PH_SEND, PH_RECV, PH_STX, PH_ETX
    } t_phase;

    typedef struct packed {
        logic             line_is_tcp;
        logic [3:0]       max_retries;
        logic [7:0]       tcp_recv_timeout;
    } t_cfg;

    typedef struct packed {
        logic             tx_valid;
        logic [7:0]       tx_byte;
        logic             resend_frame;
        logic             timer_arm;
        logic [7:0]       timer_seconds;
        logic             store_valid;
        logic [IDX_W-1:0] store_index;
        logic [7:0]       store_byte;
        logic             flush;
        logic             done_res;
        logic             done_ok;
        logic             last;
    } t_result;

    function automatic t_result f_timer(input logic [7:0] secs);
        t_result r;
        r = '0;
        r.timer_arm     = 1'b1;
        r.timer_seconds = secs;
        return r;
    endfunction

    // Completion: timer stopped and the done flag raised.
    function automatic t_result f_finish(input logic ok);
        t_result r;
        r = f_timer(8'd0);
        r.done_res = 1'b1;
        r.done_ok  = ok;
        return r;
    endfunction

    function automatic t_result f_fail_eot();
        t_result r;
        r = f_finish(1'b0);
        r.tx_valid = 1'b1;
        r.tx_byte  = C_EOT;
        return r;
    endfunction

endpackage

>>> hdl/stx_etx_bcc_link_protocol_core.sv
// Top level of the STX/ETX/BCC link protocol core: ports, configuration, input stage.
// Depends on sebl_pkg, sebl_engine, sebl_obuf and assert_macros.svh.
//
//  Channel   | Handshake                    | Contents
//  ----------+------------------------------+-----------------------------------------
//  input     | i_in_valid / o_in_stall      | i_cmd, i_start_mode, i_rx_byte
//  result    | o_out_valid / i_out_stall    | tx, resend, timer, store, flush, done, last
//  config    | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
// A request is registered at the input stage and evaluated once the result register can take
// it; its results are written into the result register, from which they are presented.
// A new request is taken every cycle while the input stage does not stall; a request that
// yields two results holds the result register until both are taken.
// Reset is synchronous and active low; it returns the engine to idle and the registers to
// line_is_tcp 0, max_retries 5, tcp_recv_timeout 30. A stalled result side backs up into
// the input stage, whose stall then rises combinationally with i_out_stall.
`include "assert_macros.svh"

module stx_etx_bcc_link_protocol_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [1:0]  i_start_mode,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_resend_frame,
    output logic        o_timer_arm,
    output logic [7:0]  o_timer_seconds,
    output logic        o_store_valid,
    output logic [13:0] o_store_index,
    output logic [7:0]  o_store_byte,
    output logic        o_flush,
    output logic        o_done_res,
    output logic        o_done_ok,
    output logic        o_last
);

    sebl_pkg::t_cfg    r_cfg;

    // Input stage
    logic              r_in_valid;
    logic [2:0]        r_cmd;
    logic [1:0]        r_mode;
    logic [7:0]        r_byte;

    logic              w_fire;
    logic              w_accept;
    logic              w_ob_ready;
    logic              w_busy;
    logic [1:0]        w_count;
    sebl_pkg::t_result w_res0, w_res1, w_out;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_is_tcp      <= 1'b0;
            r_cfg.max_retries      <= 4'd5;
            r_cfg.tcp_recv_timeout <= 8'd30;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sebl_pkg::CFG_LINE_IS_TCP: r_cfg.line_is_tcp      <= i_cfg_data[0];
                sebl_pkg::CFG_MAX_RETRIES: r_cfg.max_retries      <= i_cfg_data[3:0];
                sebl_pkg::CFG_TCP_TIMEOUT: r_cfg.tcp_recv_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The held request is evaluated once the result register will be free.
    assign w_fire     = r_in_valid & w_ob_ready;
    assign o_in_stall = r_in_valid & ~w_ob_ready;
    assign w_accept   = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_cmd;
            r_mode <= i_start_mode;
            r_byte <= i_rx_byte;
        end
    end

    sebl_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_cmd        (r_cmd),
        .i_start_mode (r_mode),
        .i_rx_byte    (r_byte),
        .i_cfg        (r_cfg),
        .o_res0       (w_res0),
        .o_res1       (w_res1),
        .o_count      (w_count),
        .o_busy       (w_busy)
    );

    sebl_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire),
        .i_count (w_count),
        .i_res0  (w_res0),
        .i_res1  (w_res1),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (w_out),
        .o_ready (w_ob_ready)
    );

    assign o_tx_valid      = w_out.tx_valid;
    assign o_tx_byte       = w_out.tx_byte;
    assign o_resend_frame  = w_out.resend_frame;
    assign o_timer_arm     = w_out.timer_arm;
    assign o_timer_seconds = w_out.timer_seconds;
    assign o_store_valid   = w_out.store_valid;
    assign o_store_index   = w_out.store_index;
    assign o_store_byte    = w_out.store_byte;
    assign o_flush         = w_out.flush;
    assign o_done_res      = w_out.done_res;
    assign o_done_ok       = w_out.done_ok;
    assign o_last          = w_out.last;

    // Every completion stops the timer.
    `SEBL_ASSERT_IMP(a_done_stops_timer, o_out_valid && o_done_res,
        o_timer_arm && (o_timer_seconds == 8'd0))
    // A delivered receive byte never carries a control byte to transmit.
    `SEBL_ASSERT_IMP(a_store_no_tx, o_out_valid && o_store_valid, !o_tx_valid)
    // After the final result of an operation the engine is idle.
    `SEBL_ASSERT_NXT(a_done_goes_idle,
        w_fire && (((w_count == 2'd1) && w_res0.done_res) ||
                   ((w_count == 2'd2) && w_res1.done_res)),
        !w_busy)

endmodule

>>> hdl/sebl_engine.sv
// Protocol engine: phase and frame state registers plus the single-pass step logic.
// Depends on sebl_pkg for codes, phase type and result helpers.
module sebl_engine (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [2:0]             i_cmd,
    input  logic [1:0]             i_start_mode,
    input  logic [7:0]             i_rx_byte,
    input  sebl_pkg::t_cfg         i_cfg,
    output sebl_pkg::t_result      o_res0,
    output sebl_pkg::t_result      o_res1,
    output logic [1:0]             o_count,
    output logic                   o_busy
);

    sebl_pkg::t_phase              r_phase, n_phase;
    logic [4:0]                    r_retry, n_retry;
    logic [7:0]                    r_check, n_check;
    logic [sebl_pkg::RCNT_W-1:0]   r_rcnt, n_rcnt;
    logic [15:0]                   r_flen, n_flen;
    logic [7:0]                    r_lenlo, n_lenlo;

    logic                          spent;
    logic [4:0]                    retry_inc;
    logic [7:0]                    rto;
    logic                          buf_room;
    logic                          bad_len;
    logic                          etx_ok;
    logic                          do_rr;
    logic                          do_fail;
    sebl_pkg::t_result             res0, res1;
    logic [1:0]                    cnt;

    assign spent     = i_cfg.line_is_tcp | (r_retry > {1'b0, i_cfg.max_retries});
    assign retry_inc = (r_retry != 5'd31) ? r_retry + 5'd1 : r_retry;
    assign rto       = i_cfg.line_is_tcp ? i_cfg.tcp_recv_timeout : sebl_pkg::T_RECV;
    assign buf_room  = r_rcnt < sebl_pkg::RCNT_W'(sebl_pkg::BUF_SIZE);
    assign bad_len   = (r_rcnt == sebl_pkg::RCNT_W'(2))
                     & ((r_flen == 16'd0) | (r_flen > 16'(sebl_pkg::BUF_SIZE)));
    assign etx_ok    = ({1'b0, r_flen} + 17'd2) <= {2'b00, r_rcnt};

    always_comb begin
        n_phase = r_phase;
        n_retry = r_retry;
        n_check = r_check;
        n_rcnt  = r_rcnt;
        n_flen  = r_flen;
        n_lenlo = r_lenlo;
        res0    = '0;
        res1    = '0;
        cnt     = 2'd0;
        do_rr   = 1'b0;
        do_fail = 1'b0;

        if (i_cmd == sebl_pkg::CMD_START) begin
            n_retry = '0;
            n_check = '0;
            n_rcnt  = '0;
            n_flen  = '0;
            n_lenlo = '0;
            cnt     = 2'd1;
            unique case (i_start_mode)
                sebl_pkg::MODE_DIAL: begin
                    n_phase = sebl_pkg::PH_DIAL;
                    res0    = sebl_pkg::f_timer(sebl_pkg::T_CONNECT);
                end
                sebl_pkg::MODE_ACCEPT: begin
                    n_phase = sebl_pkg::PH_ACCEPT;
                    res0    = sebl_pkg::f_timer(sebl_pkg::T_CONNECT);
                end
                sebl_pkg::MODE_SEND: begin
                    n_phase = sebl_pkg::PH_SEND;
                    res0    = sebl_pkg::f_timer(sebl_pkg::T_NEGOT);
                end
                default: begin
                    n_phase    = sebl_pkg::PH_RECV;
                    res0       = sebl_pkg::f_timer(rto);
                    res0.flush = 1'b1;
                end
            endcase
        end else if (r_phase != sebl_pkg::PH_IDLE) begin
            unique case (i_cmd)
                sebl_pkg::CMD_BYTE: begin
                    unique case (r_phase)
                        sebl_pkg::PH_ENQ, sebl_pkg::PH_SEND: begin
                            if (i_rx_byte == sebl_pkg::C_EOT) begin
                                do_fail = 1'b1;
                            end else if (i_rx_byte == sebl_pkg::C_ACK) begin
                                res0    = sebl_pkg::f_finish(1'b1);
                                cnt     = 2'd1;
                                n_phase = sebl_pkg::PH_IDLE;
                            end else if (i_rx_byte == sebl_pkg::C_NAK) begin
                                if (spent) begin
                                    do_fail = 1'b1;
                                end else begin
                                    res0 = sebl_pkg::f_timer(sebl_pkg::T_NEGOT);
                                    if (r_phase == sebl_pkg::PH_ENQ) begin
                                        res0.tx_valid = 1'b1;
                                        res0.tx_byte  = sebl_pkg::C_ENQ;
                                    end else begin
                                        res0.resend_frame = 1'b1;
                                    end
                                    cnt     = 2'd1;
                                    n_retry = retry_inc;
                                end
                            end
                        end
                        sebl_pkg::PH_CONN: begin
                            if (i_rx_byte == sebl_pkg::C_EOT) begin
                                do_fail = 1'b1;
                            end else if (i_rx_byte == sebl_pkg::C_ENQ) begin
                                res0          = sebl_pkg::f_finish(1'b1);
                                res0.tx_valid = 1'b1;
                                res0.tx_byte  = sebl_pkg::C_ACK;
                                cnt           = 2'd1;
                                n_phase       = sebl_pkg::PH_IDLE;
                            end
                        end
                        sebl_pkg::PH_RECV: begin
                            if (i_rx_byte == sebl_pkg::C_STX) begin
                                res0    = sebl_pkg::f_timer(rto);
                                cnt     = 2'd1;
                                n_phase = sebl_pkg::PH_STX;
                                n_check = '0;
                                n_flen  = '0;
                                n_lenlo = '0;
                            end else if (i_rx_byte == sebl_pkg::C_EOT) begin
                                res0             = sebl_pkg::f_finish(1'b1);
                                res0.store_valid = 1'b1;
                                res0.store_index = r_rcnt[sebl_pkg::IDX_W-1:0];
                                res0.store_byte  = i_rx_byte;
                                cnt              = 2'd1;
                                n_phase          = sebl_pkg::PH_IDLE;
                                if (buf_room) begin
                                    n_rcnt = r_rcnt + sebl_pkg::RCNT_W'(1);
                                end
                            end
                        end
                        sebl_pkg::PH_STX: begin
                            if (bad_len) begin
                                do_rr = 1'b1;
                            end else if (i_rx_byte == sebl_pkg::C_ETX && etx_ok) begin
                                n_check = r_check ^ i_rx_byte;
                                n_phase = sebl_pkg::PH_ETX;
                            end else if (buf_room) begin
                                res0.store_valid = 1'b1;
                                res0.store_index = r_rcnt[sebl_pkg::IDX_W-1:0];
                                res0.store_byte  = i_rx_byte;
                                cnt              = 2'd1;
                                if (r_rcnt == '0) begin
                                    n_lenlo = i_rx_byte;
                                end else if (r_rcnt == sebl_pkg::RCNT_W'(1)) begin
                                    n_flen = {i_rx_byte, r_lenlo};
                                end
                                n_rcnt  = r_rcnt + sebl_pkg::RCNT_W'(1);
                                n_check = r_check ^ i_rx_byte;
                            end else begin
                                do_fail = 1'b1;
                            end
                        end
                        sebl_pkg::PH_ETX: begin
                            if (r_check == i_rx_byte) begin
                                res0    = sebl_pkg::f_finish(r_rcnt != '0);
                                cnt     = 2'd1;
                                n_phase = sebl_pkg::PH_IDLE;
                            end else begin
                                do_rr = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                sebl_pkg::CMD_CONNECT: begin
                    if (r_phase == sebl_pkg::PH_DIAL || r_phase == sebl_pkg::PH_ACCEPT) begin
                        cnt = 2'd1;
                        if (i_cfg.line_is_tcp) begin
                            res0    = sebl_pkg::f_finish(1'b1);
                            n_phase = sebl_pkg::PH_IDLE;
                        end else if (r_phase == sebl_pkg::PH_DIAL) begin
                            n_retry       = '0;
                            res0          = sebl_pkg::f_timer(sebl_pkg::T_NEGOT);
                            res0.tx_valid = 1'b1;
                            res0.tx_byte  = sebl_pkg::C_ENQ;
                            n_phase       = sebl_pkg::PH_ENQ;
                        end else begin
                            n_retry = '0;
                            res0    = sebl_pkg::f_timer(sebl_pkg::T_ENQWAIT);
                            n_phase = sebl_pkg::PH_CONN;
                        end
                    end
                end
                sebl_pkg::CMD_DISCONN: begin
                    res0    = sebl_pkg::f_finish(1'b0);
                    cnt     = 2'd1;
                    n_phase = sebl_pkg::PH_IDLE;
                end
                sebl_pkg::CMD_TIMEOUT: begin
                    unique case (r_phase)
                        sebl_pkg::PH_DIAL, sebl_pkg::PH_ACCEPT: begin
                            res0    = sebl_pkg::f_finish(1'b0);
                            cnt     = 2'd1;
                            n_phase = sebl_pkg::PH_IDLE;
                        end
                        sebl_pkg::PH_ENQ, sebl_pkg::PH_SEND: begin
                            if (spent) begin
                                do_fail = 1'b1;
                            end else begin
                                res0 = sebl_pkg::f_timer(sebl_pkg::T_NEGOT);
                                if (r_phase == sebl_pkg::PH_ENQ) begin
                                    res0.tx_valid = 1'b1;
                                    res0.tx_byte  = sebl_pkg::C_ENQ;
                                end else begin
                                    res0.resend_frame = 1'b1;
                                end
                                cnt     = 2'd1;
                                n_retry = retry_inc;
                            end
                        end
                        sebl_pkg::PH_CONN: begin
                            // NAK goes out first; an exhausted wait then closes with EOT.
                            res0.tx_valid = 1'b1;
                            res0.tx_byte  = sebl_pkg::C_NAK;
                            cnt           = 2'd1;
                            if (!i_cfg.line_is_tcp && (r_retry < {1'b0, i_cfg.max_retries})) begin
                                res0.timer_arm     = 1'b1;
                                res0.timer_seconds = sebl_pkg::T_ENQWAIT;
                                n_retry            = retry_inc;
                            end else begin
                                do_fail = 1'b1;
                            end
                        end
                        sebl_pkg::PH_RECV, sebl_pkg::PH_STX, sebl_pkg::PH_ETX: begin
                            do_rr = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        // Receive retry: NAK and restart the frame, unless the retries are used up.
        if (do_rr) begin
            if (spent) begin
                do_fail = 1'b1;
            end else begin
                res0          = sebl_pkg::f_timer(sebl_pkg::T_NEGOT);
                res0.flush    = 1'b1;
                res0.tx_valid = 1'b1;
                res0.tx_byte  = sebl_pkg::C_NAK;
                cnt           = 2'd1;
                n_phase       = sebl_pkg::PH_RECV;
                n_rcnt        = '0;
                n_retry       = retry_inc;
            end
        end

        if (do_fail) begin
            if (cnt == 2'd0) begin
                res0 = sebl_pkg::f_fail_eot();
            end else begin
                res1 = sebl_pkg::f_fail_eot();
            end
            cnt     = cnt + 2'd1;
            n_phase = sebl_pkg::PH_IDLE;
        end

        if (cnt == 2'd1) begin
            res0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sebl_pkg::PH_IDLE;
            r_retry <= '0;
            r_check <= '0;
            r_rcnt  <= '0;
            r_flen  <= '0;
            r_lenlo <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_retry <= n_retry;
            r_check <= n_check;
            r_rcnt  <= n_rcnt;
            r_flen  <= n_flen;
            r_lenlo <= n_lenlo;
        end
    end

    assign o_res0  = res0;
    assign o_res1  = res1;
    assign o_count = cnt;
    assign o_busy  = r_phase != sebl_pkg::PH_IDLE;

endmodule

>>> hdl/sebl_obuf.sv
// Two-entry result register that holds the results of one request until taken.
// Depends on sebl_pkg for the result type.
module sebl_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [1:0]         i_count,
    input  sebl_pkg::t_result  i_res0,
    input  sebl_pkg::t_result  i_res1,
    input  logic               i_stall,
    output logic               o_valid,
    output sebl_pkg::t_result  o_res,
    output logic               o_ready
);

    logic [1:0]        r_cnt;
    sebl_pkg::t_result r_ent0, r_ent1;
    logic              pop;

    assign pop     = (r_cnt != 2'd0) & ~i_stall;
    // Ready when the buffer is empty after this cycle's pop.
    assign o_ready = (r_cnt == 2'd0) | ((r_cnt == 2'd1) & pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push) begin
            r_cnt <= i_count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent0 <= i_res0;
            r_ent1 <= i_res1;
        end else if (pop) begin
            r_ent0 <= r_ent1;
        end
    end

    assign o_valid = r_cnt != 2'd0;
    assign o_res   = r_ent0;

endmodule

>>> dv/tb_stx_etx_bcc_link_protocol_core.sv
// Self-checking testbench for the STX/ETX/BCC link protocol core: directed handshakes,
// frame errors, the largest frame length, result back-pressure and random sessions.
// Depends on sebl_pkg and stx_etx_bcc_link_protocol_core; needs nothing else.
module tb_stx_etx_bcc_link_protocol_core;

    import sebl_pkg::*;

    // Cycles a request needs to reach the result port, with some margin.
    localparam int LATENCY = 4;
    // Cycles the result side is held off during the back-pressure test.
    localparam int HOLD_CYCLES = 48;
    // Cycles with no request and no result accepted before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 1000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_cmd;
    logic [1:0]  i_start_mode;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_resend_frame;
    logic        o_timer_arm;
    logic [7:0]  o_timer_seconds;
    logic        o_store_valid;
    logic [13:0] o_store_index;
    logic [7:0]  o_store_byte;
    logic        o_flush;
    logic        o_done_res;
    logic        o_done_ok;
    logic        o_last;

    stx_etx_bcc_link_protocol_core u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------------------
    // Link engine prediction. These variables mirror the engine's own state and its
    // configuration; they are updated at the edge at which each request is accepted.
    // ------------------------------------------------------------------------------------
    t_phase      ph = PH_IDLE;
    logic [4:0]  retry_cnt = '0;
    logic [7:0]  bcc = '0;
    logic [14:0] rx_cnt = '0;
    logic [15:0] flen = '0;
    logic [7:0]  len_lo = '0;

    logic        cfg_tcp = 1'b0;
    logic [3:0]  cfg_max = 4'd5;
    logic [7:0]  cfg_tcp_secs = 8'd30;

    // Results of the request being predicted, and the line of results still awaited.
    t_result     step_res[$];
    t_result     exp_q[$];

    // Stimulus shaping, shared between the test tasks and the stall generator.
    int          gap_max = 3;
    int          burst_left = 0;
    int          stall_pct = 25;
    bit          hold_req = 1'b0;

    int          n_reqs = 0;
    int          n_active = 0;
    int          n_results = 0;
    int          n_cfg = 0;
    int          n_fail = 0;

    function automatic bit retries_out();
        return cfg_tcp || (retry_cnt > {1'b0, cfg_max});
    endfunction

    function automatic void bump_retry();
        if (retry_cnt != 5'd31)
            retry_cnt++;
    endfunction

    function automatic logic [7:0] recv_secs();
        return cfg_tcp ? cfg_tcp_secs : T_RECV;
    endfunction

    // Every completed operation stops the timer and returns the engine to idle.
    function automatic void close_op(input t_result r, input logic ok);
        r.timer_arm     = 1'b1;
        r.timer_seconds = 8'd0;
        r.done_res      = 1'b1;
        r.done_ok       = ok;
        step_res.push_back(r);
        ph = PH_IDLE;
    endfunction

    function automatic void abort_op();
        t_result r;
        r = '0;
        r.tx_valid = 1'b1;
        r.tx_byte  = C_EOT;
        close_op(r, 1'b0);
    endfunction

    // With retries left, NAK the frame, flush the stored bytes and await a fresh STX.
    function automatic void recv_retry();
        t_result r;
        if (retries_out()) begin
            abort_op();
        end else begin
            r = '0;
            r.flush         = 1'b1;
            r.tx_valid      = 1'b1;
            r.tx_byte       = C_NAK;
            r.timer_arm     = 1'b1;
            r.timer_seconds = T_NEGOT;
            step_res.push_back(r);
            ph     = PH_RECV;
            rx_cnt = '0;
            bump_retry();
        end
    endfunction

    // With retries left, re-enquire when dialling or ask the host to resend when sending.
    function automatic void negotiate_retry();
        t_result r;
        if (retries_out()) begin
            abort_op();
        end else begin
            r = '0;
            if (ph == PH_ENQ) begin
                r.tx_valid = 1'b1;
                r.tx_byte  = C_ENQ;
            end else begin
                r.resend_frame = 1'b1;
            end
            r.timer_arm     = 1'b1;
            r.timer_seconds = T_NEGOT;
            step_res.push_back(r);
            bump_retry();
        end
    endfunction

    // Works out the results of one request, appends them to the awaited results and
    // returns how many there are.
    function automatic int predict(input logic [2:0] cmd, input logic [1:0] mode,
                                   input logic [7:0] b);
        t_result r;
        step_res.delete();
        r = '0;
        if (cmd == CMD_START) begin
            // A start always wins, even over an operation still running.
            retry_cnt = '0;
            bcc       = '0;
            rx_cnt    = '0;
            flen      = '0;
            len_lo    = '0;
            r.timer_arm = 1'b1;
            case (mode)
                MODE_DIAL: begin
                    ph = PH_DIAL;
                    r.timer_seconds = T_CONNECT;
                end
                MODE_ACCEPT: begin
                    ph = PH_ACCEPT;
                    r.timer_seconds = T_CONNECT;
                end
                MODE_SEND: begin
                    ph = PH_SEND;
                    r.timer_seconds = T_NEGOT;
                end
                default: begin
                    ph = PH_RECV;
                    r.flush = 1'b1;
                    r.timer_seconds = recv_secs();
                end
            endcase
            step_res.push_back(r);
        end else if (ph != PH_IDLE) begin
            case (cmd)
                CMD_BYTE: case (ph)
                    PH_ENQ, PH_SEND: begin
                        if (b == C_EOT)
                            abort_op();
                        else if (b == C_ACK)
                            close_op(r, 1'b1);
                        else if (b == C_NAK)
                            negotiate_retry();
                    end
                    PH_CONN: begin
                        if (b == C_EOT) begin
                            abort_op();
                        end else if (b == C_ENQ) begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = C_ACK;
                            close_op(r, 1'b1);
                        end
                    end
                    PH_RECV: begin
                        if (b == C_STX) begin
                            r.timer_arm     = 1'b1;
                            r.timer_seconds = recv_secs();
                            step_res.push_back(r);
                            ph     = PH_STX;
                            bcc    = '0;
                            flen   = '0;
                            len_lo = '0;
                        end else if (b == C_EOT) begin
                            // The EOT itself is delivered into the buffer.
                            r.store_valid = 1'b1;
                            r.store_index = rx_cnt[13:0];
                            r.store_byte  = b;
                            if (rx_cnt < BUF_SIZE)
                                rx_cnt++;
                            close_op(r, 1'b1);
                        end
                    end
                    PH_STX: begin
                        if (rx_cnt == 2 && (flen == 0 || flen > BUF_SIZE)) begin
                            // Bad length: the byte is dropped and the frame refused.
                            recv_retry();
                        end else if (b == C_ETX && int'(flen) + 2 <= int'(rx_cnt)) begin
                            bcc = bcc ^ b;
                            ph  = PH_ETX;
                        end else if (rx_cnt < BUF_SIZE) begin
                            r.store_valid = 1'b1;
                            r.store_index = rx_cnt[13:0];
                            r.store_byte  = b;
                            step_res.push_back(r);
                            if (rx_cnt == 0)
                                len_lo = b;
                            else if (rx_cnt == 1)
                                flen = {b, len_lo};
                            rx_cnt++;
                            bcc = bcc ^ b;
                        end else begin
                            // No room left in the receive buffer.
                            abort_op();
                        end
                    end
                    PH_ETX: begin
                        if (bcc == b)
                            close_op(r, rx_cnt != 0);
                        else
                            recv_retry();
                    end
                    default: ;
                endcase
                CMD_CONNECT: begin
                    if (ph == PH_DIAL || ph == PH_ACCEPT) begin
                        if (cfg_tcp) begin
                            close_op(r, 1'b1);
                        end else begin
                            retry_cnt   = '0;
                            r.timer_arm = 1'b1;
                            if (ph == PH_DIAL) begin
                                r.tx_valid      = 1'b1;
                                r.tx_byte       = C_ENQ;
                                r.timer_seconds = T_NEGOT;
                                ph = PH_ENQ;
                            end else begin
                                r.timer_seconds = T_ENQWAIT;
                                ph = PH_CONN;
                            end
                            step_res.push_back(r);
                        end
                    end
                end
                CMD_DISCONN: close_op(r, 1'b0);
                CMD_TIMEOUT: case (ph)
                    PH_DIAL, PH_ACCEPT: close_op(r, 1'b0);
                    PH_ENQ, PH_SEND: negotiate_retry();
                    PH_CONN: begin
                        // The NAK goes out either way; a spent retry budget adds an EOT.
                        r.tx_valid = 1'b1;
                        r.tx_byte  = C_NAK;
                        if (!cfg_tcp && retry_cnt < {1'b0, cfg_max}) begin
                            r.timer_arm     = 1'b1;
                            r.timer_seconds = T_ENQWAIT;
                            step_res.push_back(r);
                            bump_retry();
                        end else begin
                            step_res.push_back(r);
                            abort_op();
                        end
                    end
                    PH_RECV, PH_STX, PH_ETX: recv_retry();
                    default: ;
                endcase
                default: ;
            endcase
        end
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[k])
            exp_q.push_back(step_res[k]);
        return step_res.size();
    endfunction

    // ------------------------------------------------------------------------------------
    // Request side. The sender works in bursts; between bursts it drops valid for a
    // random gap. Valid is never lowered here after an acceptance, so that a following
    // request in the same burst keeps it high without a second assignment in the step.
    // ------------------------------------------------------------------------------------
    task automatic send_req(input logic [2:0] cmd, input logic [1:0] mode,
                            input logic [7:0] b);
        if (gap_max > 0 && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_start_mode <= mode;
        i_rx_byte    <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        n_reqs++;
        if (predict(cmd, mode, b) > 0)
            n_active++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(CMD_BYTE, 2'($urandom), b);
    endtask

    task automatic send_event(input logic [2:0] cmd);
        send_req(cmd, 2'($urandom), 8'($urandom));
    endtask

    // Stops sending and waits until every awaited result has arrived, plus the latency
    // of a request that may still be on its way without producing a result.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (exp_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // Writes all three registers; only called once the engine has gone quiet.
    task automatic write_config(input logic tcp, input logic [3:0] maxr,
                                input logic [7:0] secs);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LINE_IS_TCP;
        i_cfg_data  <= {7'd0, tcp};
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_RETRIES;
        i_cfg_data  <= {4'd0, maxr};
        @(posedge i_clk);
        i_cfg_index <= CFG_TCP_TIMEOUT;
        i_cfg_data  <= secs;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        cfg_tcp      = tcp;
        cfg_max      = maxr;
        cfg_tcp_secs = secs;
        n_cfg++;
    endtask

    // ------------------------------------------------------------------------------------
    // Result side. Stalls come in short runs at a rate set by the current test; a long
    // hold-off can be requested, and is counted out here in cycles.
    // ------------------------------------------------------------------------------------
    initial begin : result_backpressure
        int run;
        run = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
                run = 0;
            end else if (run > 0) begin
                run--;
            end else begin
                run = $urandom_range(0, 3);
                i_out_stall <= ($urandom_range(1, 100) <= stall_pct);
            end
        end
    end

    function automatic void cmp(input string fname, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            n_fail++;
        end
    endfunction

    // Each accepted result is compared with the oldest one awaited.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (exp_q.size() == 0) begin
                $error("result arrived with none awaited");
                n_fail++;
            end else begin
                want = exp_q.pop_front();
                cmp("tx_valid", want.tx_valid, o_tx_valid);
                cmp("tx_byte", want.tx_byte, o_tx_byte);
                cmp("resend_frame", want.resend_frame, o_resend_frame);
                cmp("timer_arm", want.timer_arm, o_timer_arm);
                cmp("timer_seconds", want.timer_seconds, o_timer_seconds);
                cmp("store_valid", want.store_valid, o_store_valid);
                cmp("store_index", want.store_index, o_store_index);
                cmp("store_byte", want.store_byte, o_store_byte);
                cmp("flush", want.flush, o_flush);
                cmp("done_res", want.done_res, o_done_res);
                cmp("done_ok", want.done_ok, o_done_ok);
                cmp("last", want.last, o_last);
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("stx_etx_bcc_link_protocol_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // An idle engine ignores everything but a start, and unused command codes do nothing.
    task automatic test_idle_events();
        send_byte(C_ENQ);
        send_event(CMD_CONNECT);
        send_event(CMD_DISCONN);
        send_event(CMD_TIMEOUT);
        send_event(3'd5);
        send_event(3'd6);
        send_event(3'd7);
    endtask

    // Dial under the reset configuration: enquiry, one NAK, one timeout, then ACK.
    task automatic test_dial();
        send_req(CMD_START, MODE_DIAL, 8'h00);
        send_event(CMD_CONNECT);
        send_byte(C_NAK);
        send_event(CMD_TIMEOUT);
        send_byte(C_ACK);
    endtask

    // Accept: the peer's enquiry comes after one timeout and is acknowledged.
    task automatic test_accept();
        send_req(CMD_START, MODE_ACCEPT, 8'hFF);
        send_event(CMD_CONNECT);
        send_event(CMD_TIMEOUT);
        send_byte(C_ENQ);
    endtask

    // Send: a connect means nothing here, a NAK asks for the frame again, EOT fails.
    task automatic test_send();
        send_req(CMD_START, MODE_SEND, 8'h00);
        send_event(CMD_CONNECT);
        send_byte(C_NAK);
        send_byte(C_EOT);
    endtask

    // A good frame of three bytes whose first data byte has the value of ETX.
    task automatic test_frame_receive();
        send_req(CMD_START, MODE_RECV, 8'h00);
        send_byte(C_STX);
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(C_ETX);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(C_ETX);
        send_byte(8'hFC);
    endtask

    // Lengths of zero and beyond the buffer are refused, then a start abandons the
    // receive and a disconnect ends the dial with an error.
    task automatic test_bad_length();
        send_req(CMD_START, MODE_RECV, 8'h00);
        send_byte(C_STX);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(C_STX);
        send_byte(8'h01);
        send_byte(8'h40);
        send_byte(8'hAA);
        send_byte(C_STX);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h11);
        send_req(CMD_START, MODE_DIAL, 8'h00);
        send_event(CMD_DISCONN);
    endtask

    // A frame announcing the largest length is taken; a timeout then abandons it.
    task automatic test_largest_length();
        int i;
        send_req(CMD_START, MODE_RECV, 8'h00);
        send_byte(C_STX);
        send_byte(8'h00);
        send_byte(8'h40);
        for (i = 0; i < 6; i++)
            send_byte(8'($urandom));
        send_byte(C_ETX);
        send_event(CMD_TIMEOUT);
    endtask

    // The result side holds off for a long stretch while requests keep coming, so the
    // core fills up and stalls its input; afterwards the sender waits for everything.
    task automatic test_result_hold();
        int i;
        logic [7:0] d;
        logic [7:0] sum;
        drain();
        gap_max   = 0;
        stall_pct = 0;
        send_req(CMD_START, MODE_RECV, 8'h00);
        hold_req = 1'b1;
        send_byte(C_STX);
        send_byte(8'd40);
        send_byte(8'd0);
        sum = 8'd40;
        for (i = 0; i < 40; i++) begin
            d = 8'($urandom);
            sum = sum ^ d;
            send_byte(d);
        end
        send_byte(C_ETX);
        send_byte(sum ^ C_ETX);
        drain();
    endtask

    // One protocol session: a start of any kind, then events that mostly make sense in
    // the current phase, with some noise, restarts and disconnects mixed in.
    task automatic random_session();
        int steps;
        int roll;
        int i;
        logic [15:0] len;
        logic [7:0] d;
        logic [7:0] sum;
        send_req(CMD_START, 2'($urandom), 8'($urandom));
        steps = 0;
        while (ph != PH_IDLE && steps < 40) begin
            steps++;
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                send_req(3'($urandom), 2'($urandom), 8'($urandom));
            end else begin
                case (ph)
                    PH_DIAL, PH_ACCEPT: begin
                        if (roll < 90)
                            send_event(CMD_CONNECT);
                        else
                            send_event(CMD_TIMEOUT);
                    end
                    PH_ENQ, PH_SEND: begin
                        if (roll < 45)
                            send_byte(C_NAK);
                        else if (roll < 65)
                            send_event(CMD_TIMEOUT);
                        else if (roll < 88)
                            send_byte(C_ACK);
                        else
                            send_byte(C_EOT);
                    end
                    PH_CONN: begin
                        if (roll < 45)
                            send_event(CMD_TIMEOUT);
                        else if (roll < 85)
                            send_byte(C_ENQ);
                        else
                            send_byte(C_EOT);
                    end
                    PH_RECV: begin
                        if (roll < 80) begin
                            // A frame, mostly short and well formed.
                            send_byte(C_STX);
                            roll = $urandom_range(0, 99);
                            if (roll < 6)
                                len = 16'd0;
                            else if (roll < 12)
                                len = 16'($urandom_range(BUF_SIZE + 1, 65535));
                            else
                                len = 16'($urandom_range(1, 12));
                            sum = len[7:0] ^ len[15:8];
                            send_byte(len[7:0]);
                            send_byte(len[15:8]);
                            for (i = 0; i < len && ph == PH_STX; i++) begin
                                if ($urandom_range(0, 99) < 3) begin
                                    send_event(CMD_TIMEOUT);
                                end else begin
                                    d = 8'($urandom);
                                    sum = sum ^ d;
                                    send_byte(d);
                                end
                            end
                            if (ph == PH_STX) begin
                                send_byte(C_ETX);
                                sum = sum ^ C_ETX;
                            end
                            if (ph == PH_ETX) begin
                                if ($urandom_range(0, 99) < 88)
                                    send_byte(sum);
                                else
                                    send_byte(sum ^ 8'($urandom_range(1, 255)));
                            end
                        end else if (roll < 90) begin
                            send_byte(C_EOT);
                        end else begin
                            send_event(CMD_TIMEOUT);
                        end
                    end
                    default: send_event(CMD_TIMEOUT);
                endcase
            end
        end
    endtask

    // Random sessions under several configurations, extremes first, each with its own
    // idling pattern; the first round has no idling on either side.
    task automatic test_random_traffic();
        int round;
        int target;
        for (round = 0; round < 6; round++) begin
            drain();
            case (round)
                0: begin write_config(1'b0, 4'd15, 8'd255); gap_max = 0; stall_pct = 0; end
                1: begin write_config(1'b0, 4'd0, 8'd0); gap_max = 4; stall_pct = 30; end
                2: begin write_config(1'b1, 4'd0, 8'd255); gap_max = 6; stall_pct = 20; end
                3: begin write_config(1'b1, 4'd15, 8'd0); gap_max = 3; stall_pct = 50; end
                4: begin
                    write_config(1'b0, 4'($urandom), 8'($urandom));
                    gap_max = 8;
                    stall_pct = 40;
                end
                default: begin
                    write_config(1'b1, 4'($urandom), 8'($urandom));
                    gap_max = 2;
                    stall_pct = 10;
                end
            endcase
            target = n_active + 65;
            while (n_active < target)
                random_session();
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_LINE_IS_TCP;
        i_cfg_data   <= 8'd0;
        i_in_valid   <= 1'b0;
        i_cmd        <= CMD_START;
        i_start_mode <= MODE_DIAL;
        i_rx_byte    <= 8'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The directed part runs under the configuration left by reset.
        test_idle_events();
        test_dial();
        test_accept();
        test_send();
        test_frame_receive();
        test_bad_length();
        test_largest_length();
        test_result_hold();
        test_random_traffic();

        drain();
        repeat (LATENCY) @(posedge i_clk);
        $display("Sent %0d requests (%0d with results), checked %0d results, %0d configurations;",
                 n_reqs, n_active, n_results, n_cfg + 1);
        $display("dial, accept, send and receive sessions, bad lengths and a long hold-off ran.");
        if (n_fail == 0)
            $display("stx_etx_bcc_link_protocol_core: match");
        else
            $display("stx_etx_bcc_link_protocol_core: mismatch");
        $finish;
    end

endmodule
